>>> hw/rtl/rrsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrsa_pkg
// Shared types, constants and the fold helper for the rounded-rectangle
// shadow alpha pipeline.
// ----------------------------------------------------------------------------
package rrsa_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int FOLD_W         = 19;
   localparam int DIST_W         = 10;
   localparam int FOLD_MAX       = 1023;
   localparam int LIN_W          = DIST_W + 4;
   localparam int RAD_W          = 2 * DIST_W + 1 + 8;
   localparam int ROOT_W         = 16;
   localparam int ROOT_STG       = ROOT_W / 2;
   localparam int ST_REL         = 0;
   localparam int ST_FOLD        = 1;
   localparam int ST_SQ          = 2;
   localparam int ST_ROOT        = 3;
   localparam int ST_CMP         = ST_ROOT + ROOT_STG;
   localparam int ST_MUL         = ST_CMP + 1;
   localparam int ST_OUT         = ST_MUL + 1;
   localparam int NSTG           = ST_OUT + 1;

   typedef enum logic [2:0] {
      REG_ORIGIN_X     = 3'd0,
      REG_ORIGIN_Y     = 3'd1,
      REG_BOX_WIDTH    = 3'd2,
      REG_BOX_HEIGHT   = 3'd3,
      REG_OUTER_RADIUS = 3'd4,
      REG_INNER_BORDER = 3'd5,
      REG_ALPHA_FULL   = 3'd6,
      REG_ALPHA_SLOPE  = 3'd7
   } rrsa_reg_type;

   typedef struct packed {
      logic             both;
      logic [LIN_W-1:0] d_lin;
   } rrsa_side_type;

   typedef struct packed {
      logic              pos;
      logic [DIST_W-1:0] mag;
   } rrsa_fold_type;

   function automatic rrsa_fold_type fold_dist(input logic signed [FOLD_W-1:0] rel,
                                               input logic [14:0] size,
                                               input logic [8:0] rad);
      logic signed [FOLD_W-1:0] s;
      logic signed [FOLD_W-1:0] r;
      logic signed [FOLD_W-1:0] f;
      rrsa_fold_type            res;
      s = signed'(FOLD_W'(size));
      r = signed'(FOLD_W'(rad));
      if (rel >= s - r) begin
         f = rel + r - s + FOLD_W'(1);
      end else begin
         f = r - rel;
      end
      res.pos = (f > FOLD_W'(0));
      if (f > FOLD_W'(FOLD_MAX)) begin
         res.mag = '1;
      end else begin
         res.mag = f[DIST_W-1:0];
      end
      return res;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/rrsa_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrsa_isqrt
// Pipelined integer square root with a 16-bit result, two result bits per stage, carrying
// the side data of each request alongside.
// ----------------------------------------------------------------------------
module rrsa_isqrt (
   input  wire logic                          clock,
   input  wire logic [rrsa_pkg::ROOT_STG-1:0] stage_en,
   input  wire logic [rrsa_pkg::RAD_W-1:0]    rad_in,
   input  wire rrsa_pkg::rrsa_side_type       side_in,
   output logic [rrsa_pkg::ROOT_W-1:0]        root_out,
   output rrsa_pkg::rrsa_side_type            side_out
);
   import rrsa_pkg::*;

   typedef struct packed {
      logic [ROOT_W-1:0] r;
      logic [RAD_W-1:0]  sq;
   } acc_type;

   function automatic acc_type root_bit(input logic [RAD_W-1:0] v, input acc_type acc,
                                        input logic [3:0] b);
      logic [31:0] trial;
      acc_type     res;
      res   = acc;
      trial = 32'(acc.sq) + (32'(acc.r) << (5'(b) + 5'd1)) + (32'd1 << {b, 1'b0});
      if (trial <= 32'(v)) begin
         res.sq = trial[RAD_W-1:0];
         res.r  = acc.r | (ROOT_W'(1) << b);
      end
      return res;
   endfunction

   logic [RAD_W-1:0] v_ff  [ROOT_STG-1];
   logic [RAD_W-1:0] sq_ff [ROOT_STG-1];
   logic [ROOT_W-1:0] r_ff [ROOT_STG];
   rrsa_side_type side_ff  [ROOT_STG];
   acc_type acc_in [ROOT_STG];

   always_comb begin
      acc_type          a;
      logic [RAD_W-1:0] v;
      for (int j = 0; j < ROOT_STG; j++) begin
         if (j == 0) begin
            a.r  = '0;
            a.sq = '0;
            v    = rad_in;
         end else begin
            a.r  = r_ff[j-1];
            a.sq = sq_ff[j-1];
            v    = v_ff[j-1];
         end
         a          = root_bit(v, a, 4'(ROOT_W - 1 - 2 * j));
         a          = root_bit(v, a, 4'(ROOT_W - 2 - 2 * j));
         acc_in[j]  = a;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < ROOT_STG; j++) begin
         if (stage_en[j]) begin
            r_ff[j]    <= acc_in[j].r;
            side_ff[j] <= (j == 0) ? side_in : side_ff[(j == 0) ? 0 : j - 1];
         end
      end
      for (int j = 0; j < ROOT_STG - 1; j++) begin
         if (stage_en[j]) begin
            sq_ff[j] <= acc_in[j].sq;
            v_ff[j]  <= (j == 0) ? rad_in : v_ff[(j == 0) ? 0 : j - 1];
         end
      end
   end

   assign root_out = r_ff[ROOT_STG-1];
   assign side_out = side_ff[ROOT_STG-1];

endmodule
`default_nettype wire

>>> hw/rtl/rounded_rect_shadow_alpha_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rounded_rect_shadow_alpha_top
// Alpha of a blurred rounded-rectangle shadow, one pixel per request.
// ----------------------------------------------------------------------------
// Takes one pixel request per clock when the response side does not stall
// and returns its alpha. The depth of the pipeline is set by the square
// root, which resolves two result bits per stage over eight stages, framed
// by offset, fold, square-sum, compare, multiply and output stages. Stalls
// back up only as far as the first empty stage, so bubbles are absorbed.
// Write the control registers only while no request is in flight.
module rounded_rect_shadow_alpha_top #(
   parameter int COORD_BITS = rrsa_pkg::COORD_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_pixel_x,
   input  wire logic [15:0] req_pixel_y,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_alpha,
   input  wire logic        csr_wen,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import rrsa_pkg::*;

   localparam int REL_W = COORD_BITS + 1;

   logic [15:0] origin_x_ff;
   logic [15:0] origin_y_ff;
   logic [14:0] box_w_ff;
   logic [14:0] box_h_ff;
   logic [8:0]  outer_ff;
   logic [7:0]  inner_ff;
   logic [7:0]  full_ff;
   logic [15:0] slope_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         box_w_ff    <= '0;
         box_h_ff    <= '0;
         outer_ff    <= '0;
         inner_ff    <= '0;
         full_ff     <= '0;
         slope_ff    <= '0;
      end else if (csr_wen) begin
         case (rrsa_reg_type'(csr_index))
            REG_ORIGIN_X:     origin_x_ff <= csr_wdata;
            REG_ORIGIN_Y:     origin_y_ff <= csr_wdata;
            REG_BOX_WIDTH:    box_w_ff    <= csr_wdata[14:0];
            REG_BOX_HEIGHT:   box_h_ff    <= csr_wdata[14:0];
            REG_OUTER_RADIUS: outer_ff    <= csr_wdata[8:0];
            REG_INNER_BORDER: inner_ff    <= csr_wdata[7:0];
            REG_ALPHA_FULL:   full_ff     <= csr_wdata[7:0];
            REG_ALPHA_SLOPE:  slope_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage control
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;
   logic [NSTG-1:0] en;

   assign vld_in = {vld_ff[NSTG-2:0], req_valid};

   always_comb begin
      en[NSTG-1] = !vld_ff[NSTG-1] || !rsp_stall;
      for (int k = NSTG - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NSTG; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   assign req_stall = !en[ST_REL];
   assign rsp_valid = vld_ff[ST_OUT];

   // offset
   logic signed [REL_W-1:0] px_ext, py_ext, ox_ext, oy_ext;
   logic signed [REL_W-1:0] rx_ff, ry_ff;

   assign px_ext = REL_W'(signed'(req_pixel_x[COORD_BITS-1:0]));
   assign py_ext = REL_W'(signed'(req_pixel_y[COORD_BITS-1:0]));
   assign ox_ext = REL_W'(signed'(origin_x_ff[COORD_BITS-1:0]));
   assign oy_ext = REL_W'(signed'(origin_y_ff[COORD_BITS-1:0]));

   always_ff @(posedge clock) begin
      if (en[ST_REL]) begin
         rx_ff <= px_ext - ox_ext;
         ry_ff <= py_ext - oy_ext;
      end
   end

   // fold into one corner
   rrsa_fold_type fx_ff, fy_ff;

   always_ff @(posedge clock) begin
      if (en[ST_FOLD]) begin
         fx_ff <= fold_dist(FOLD_W'(rx_ff), box_w_ff, outer_ff);
         fy_ff <= fold_dist(FOLD_W'(ry_ff), box_h_ff, outer_ff);
      end
   end

   // squared distance and edge diffusion
   logic [2*DIST_W-1:0] sqx, sqy;
   logic [2*DIST_W:0]   sq_sum;
   logic [RAD_W-1:0]    rad_ff;
   rrsa_side_type       side_in, side_ff;

   assign sqx    = (2*DIST_W)'(fx_ff.mag) * (2*DIST_W)'(fx_ff.mag);
   assign sqy    = (2*DIST_W)'(fy_ff.mag) * (2*DIST_W)'(fy_ff.mag);
   assign sq_sum = (2*DIST_W+1)'(sqx) + (2*DIST_W+1)'(sqy);

   always_comb begin
      side_in.both = fx_ff.pos && fy_ff.pos;
      if (fx_ff.pos) begin
         side_in.d_lin = {fx_ff.mag, 4'b0000};
      end else if (fy_ff.pos) begin
         side_in.d_lin = {fy_ff.mag, 4'b0000};
      end else begin
         side_in.d_lin = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_SQ]) begin
         rad_ff  <= {sq_sum, 8'h00};
         side_ff <= side_in;
      end
   end

   // square root
   logic [ROOT_W-1:0] root;
   rrsa_side_type     side_root;

   rrsa_isqrt u_isqrt (
      .clock    (clock),
      .stage_en (en[ST_ROOT +: ROOT_STG]),
      .rad_in   (rad_ff),
      .side_in  (side_ff),
      .root_out (root),
      .side_out (side_root)
   );

   // border and radius compare
   logic [ROOT_W-1:0] d, lo, hi;
   logic              over_lo_ff, over_hi_ff;
   logic [ROOT_W-1:0] diff_ff;

   assign d  = side_root.both ? root : ROOT_W'(side_root.d_lin);
   assign lo = ROOT_W'({inner_ff, 4'b0000});
   assign hi = ROOT_W'({outer_ff, 4'b0000});

   always_ff @(posedge clock) begin
      if (en[ST_CMP]) begin
         over_lo_ff <= d > lo;
         over_hi_ff <= d > hi;
         diff_ff    <= d - lo;
      end
   end

   // ramp product
   logic [31:0] prod_ff;
   logic        m_over_lo_ff, m_over_hi_ff;

   always_ff @(posedge clock) begin
      if (en[ST_MUL]) begin
         prod_ff      <= 32'(diff_ff) * 32'(slope_ff);
         m_over_lo_ff <= over_lo_ff;
         m_over_hi_ff <= over_hi_ff;
      end
   end

   // alpha
   logic [19:0] drop;
   logic [7:0]  alpha_in;
   logic [7:0]  rsp_alpha_ff;

   assign drop = prod_ff[31:12];

   always_comb begin
      if (!m_over_lo_ff) begin
         alpha_in = full_ff;
      end else if (m_over_hi_ff || drop >= 20'(full_ff)) begin
         alpha_in = '0;
      end else begin
         alpha_in = full_ff - drop[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) begin
         rsp_alpha_ff <= alpha_in;
      end
   end

   assign rsp_alpha = rsp_alpha_ff;

endmodule
`default_nettype wire

>>> hw/rtl/rrsa_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrsa_check
// Port-level checks for the shadow alpha block, bound to the top level.
// ----------------------------------------------------------------------------
module rrsa_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_alpha,
   input wire logic        csr_wen,
   input wire logic [2:0]  csr_index,
   input wire logic [15:0] csr_wdata
);
   import rrsa_pkg::*;

   logic [7:0] full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= '0;
      end else if (csr_wen && csr_index == REG_ALPHA_FULL) begin
         full_ff <= csr_wdata[7:0];
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_alpha))
      else $error("stalled response changed");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with response side free");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid straight after reset");

   a_alpha_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_alpha <= full_ff)
      else $error("alpha above full strength");

endmodule

bind rounded_rect_shadow_alpha_top rrsa_check u_check (.*);
`default_nettype wire
